// ===== hw/rtl/aor_pkg.sv =====
// Types, widths and helpers shared by the box overlap resolver.
// No dependencies.
`default_nettype none

package aor_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned SIZE_W  = COORD_W - 1;
  localparam int unsigned MASS_W  = 16;
  // quotient of (p2 * (ma + mb)) / 4 over one mass
  localparam int unsigned QUO_W   = COORD_W + MASS_W - 1;
  localparam int unsigned SUM_W   = QUO_W + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic [SIZE_W-1:0]         a_width;
    logic [SIZE_W-1:0]         a_height;
    logic                      a_fixed;
    logic [MASS_W-1:0]         a_mass;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic [SIZE_W-1:0]         b_width;
    logic [SIZE_W-1:0]         b_height;
    logic                      b_fixed;
    logic [MASS_W-1:0]         b_mass;
  } aor_in_t;

  typedef struct packed {
    logic                      overlap;
    logic signed [COORD_W-1:0] new_a_x;
    logic signed [COORD_W-1:0] new_a_y;
    logic signed [COORD_W-1:0] new_b_x;
    logic signed [COORD_W-1:0] new_b_y;
    logic                      hit_a;
    logic                      hit_b;
  } aor_out_t;

  // data carried alongside the divider
  typedef struct packed {
    logic                      ov;
    logic                      vert;
    logic                      a_fixed;
    logic                      b_fixed;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic [COORD_W-1:0]        p2;
  } aor_side_t;

  function automatic logic signed [COORD_W-1:0] aor_sat(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-COORD_W:0] top;
    logic signed [COORD_W-1:0] r;
    top = v[SUM_W-1:COORD_W-1];
    if (top == '0 || top == '1) begin
      r = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aor_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two divisors
// sharing one dividend, with a sideband carried in step. No dependencies.
`default_nettype none

module aor_div #(
  parameter int unsigned NUM_W  = 39,
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_a_i,
  input  wire logic [DEN_W-1:0]  den_b_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [NUM_W-1:0]       quo_a_o,
  output logic [NUM_W-1:0]       quo_b_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic              v_q     [NUM_W];
  logic [DEN_W-1:0]  rem_a_q [NUM_W];
  logic [DEN_W-1:0]  rem_b_q [NUM_W];
  // dividend bits shift out at the top, quotient bits shift in at the bottom
  logic [NUM_W-1:0]  sh_a_q  [NUM_W];
  logic [NUM_W-1:0]  sh_b_q  [NUM_W];
  logic [DEN_W-1:0]  den_a_q [NUM_W];
  logic [DEN_W-1:0]  den_b_q [NUM_W];
  logic [SIDE_W-1:0] side_q  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              v_p;
    logic [DEN_W-1:0]  rem_a_p, rem_b_p, den_a_p, den_b_p;
    logic [NUM_W-1:0]  sh_a_p, sh_b_p;
    logic [SIDE_W-1:0] side_p;
    logic [DEN_W:0]    t_a, t_b, df_a, df_b;
    logic              ge_a, ge_b;
    logic [DEN_W-1:0]  rem_a_d, rem_b_d;
    logic [NUM_W-1:0]  sh_a_d, sh_b_d;

    if (k == 0) begin : g_first
      assign v_p     = valid_i;
      assign rem_a_p = '0;
      assign rem_b_p = '0;
      assign sh_a_p  = num_i;
      assign sh_b_p  = num_i;
      assign den_a_p = den_a_i;
      assign den_b_p = den_b_i;
      assign side_p  = side_i;
    end else begin : g_next
      assign v_p     = v_q[k-1];
      assign rem_a_p = rem_a_q[k-1];
      assign rem_b_p = rem_b_q[k-1];
      assign sh_a_p  = sh_a_q[k-1];
      assign sh_b_p  = sh_b_q[k-1];
      assign den_a_p = den_a_q[k-1];
      assign den_b_p = den_b_q[k-1];
      assign side_p  = side_q[k-1];
    end

    always_comb begin
      t_a     = {rem_a_p, sh_a_p[NUM_W-1]};
      t_b     = {rem_b_p, sh_b_p[NUM_W-1]};
      df_a    = t_a - {1'b0, den_a_p};
      df_b    = t_b - {1'b0, den_b_p};
      ge_a    = t_a >= {1'b0, den_a_p};
      ge_b    = t_b >= {1'b0, den_b_p};
      rem_a_d = ge_a ? df_a[DEN_W-1:0] : t_a[DEN_W-1:0];
      rem_b_d = ge_b ? df_b[DEN_W-1:0] : t_b[DEN_W-1:0];
      sh_a_d  = {sh_a_p[NUM_W-2:0], ge_a};
      sh_b_d  = {sh_b_p[NUM_W-2:0], ge_b};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_a_q[k] <= rem_a_d;
      rem_b_q[k] <= rem_b_d;
      sh_a_q[k]  <= sh_a_d;
      sh_b_q[k]  <= sh_b_d;
      den_a_q[k] <= den_a_p;
      den_b_q[k] <= den_b_p;
      side_q[k]  <= side_p;
    end
  end

  assign valid_o = v_q[NUM_W-1];
  assign quo_a_o = sh_a_q[NUM_W-1];
  assign quo_b_o = sh_b_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_overlap_resolve_core.sv =====
// Box pair overlap test and minimum-penetration resolution, fully pipelined.
// Depends on aor_pkg and aor_div.
//
//  Channel  Handshake         Payload               Behaviour
//  input    start_i, busy_o   in_i (aor_in_t)       busy_o tied low, a pair every cycle
//  result   done_o            result_o (aor_out_t)  one-cycle strobe, no back-pressure
//
// One pair per cycle; the pipeline runs through the input register, geometry and
// multiply stages, the mass divider (one quotient bit per stage) and the output register.
// Reset clears only the valid bits; results cannot be held off, so nothing stalls.
`default_nettype none

module aabb_overlap_resolve_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire aor_pkg::aor_in_t in_i,
  output logic                  done_o,
  output aor_pkg::aor_out_t     result_o
);
  import aor_pkg::*;

  // input register
  logic    v1_q;
  aor_in_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end
  always_ff @(posedge clk_i) begin
    in_q <= in_i;
  end

  // geometry stage
  logic [COORD_W:0]          dx_raw, dy_raw, dx_neg, dy_neg;
  logic [COORD_W-1:0]        adx, ady;
  logic [COORD_W-1:0]        sw, sh;
  logic signed [COORD_W+1:0] px2, py2;
  aor_side_t                 side_d, side2_q;
  logic [MASS_W-1:0]         ma_d, mb_d, ma2_q, mb2_q;
  logic                      v2_q;

  always_comb begin
    dx_raw = {in_q.a_x[COORD_W-1], in_q.a_x} - {in_q.b_x[COORD_W-1], in_q.b_x};
    dy_raw = {in_q.a_y[COORD_W-1], in_q.a_y} - {in_q.b_y[COORD_W-1], in_q.b_y};
    dx_neg = -dx_raw;
    dy_neg = -dy_raw;
    adx    = dx_raw[COORD_W] ? dx_neg[COORD_W-1:0] : dx_raw[COORD_W-1:0];
    ady    = dy_raw[COORD_W] ? dy_neg[COORD_W-1:0] : dy_raw[COORD_W-1:0];
    sw     = {1'b0, in_q.a_width} + {1'b0, in_q.b_width};
    sh     = {1'b0, in_q.a_height} + {1'b0, in_q.b_height};
    px2    = $signed({2'b00, sw}) - $signed({1'b0, adx, 1'b0});
    py2    = $signed({2'b00, sh}) - $signed({1'b0, ady, 1'b0});

    side_d.ov      = !px2[COORD_W+1] && !py2[COORD_W+1];
    side_d.vert    = px2 > py2;
    side_d.a_fixed = in_q.a_fixed;
    side_d.b_fixed = in_q.b_fixed;
    side_d.a_x     = in_q.a_x;
    side_d.a_y     = in_q.a_y;
    side_d.b_x     = in_q.b_x;
    side_d.b_y     = in_q.b_y;
    side_d.p2      = side_d.vert ? py2[COORD_W-1:0] : px2[COORD_W-1:0];
    ma_d = (in_q.a_mass == '0) ? MASS_W'(1) : in_q.a_mass;
    mb_d = (in_q.b_mass == '0) ? MASS_W'(1) : in_q.b_mass;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    side2_q <= side_d;
    ma2_q   <= ma_d;
    mb2_q   <= mb_d;
  end

  // multiply stage: p2 * (ma + mb), quartered
  logic [MASS_W:0]          tot;
  logic [COORD_W+MASS_W:0]  prod;
  logic [QUO_W-1:0]         num3_q;
  aor_side_t                side3_q;
  logic [MASS_W-1:0]        ma3_q, mb3_q;
  logic                     v3_q;

  always_comb begin
    tot  = {1'b0, ma2_q} + {1'b0, mb2_q};
    prod = side2_q.p2 * tot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    num3_q  <= prod[COORD_W+MASS_W:2];
    side3_q <= side2_q;
    ma3_q   <= ma2_q;
    mb3_q   <= mb2_q;
  end

  // divide by each mass
  logic             vd;
  logic [QUO_W-1:0] qa, qb;
  aor_side_t        sd;

  aor_div #(
    .NUM_W  (QUO_W),
    .DEN_W  (MASS_W),
    .SIDE_W ($bits(aor_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .num_i   (num3_q),
    .den_a_i (ma3_q),
    .den_b_i (mb3_q),
    .side_i  (side3_q),
    .valid_o (vd),
    .quo_a_o (qa),
    .quo_b_o (qb),
    .side_o  (sd)
  );

  // apply pushes and saturate
  logic signed [SUM_W-1:0] half, quart, sqa, sqb;
  logic signed [SUM_W-1:0] dax, day, dbx, dby;
  aor_out_t                res_d, res_q;
  logic                    done_q;

  always_comb begin
    half  = $signed({{(SUM_W-COORD_W+1){1'b0}}, sd.p2[COORD_W-1:1]});
    quart = $signed({{(SUM_W-COORD_W+2){1'b0}}, sd.p2[COORD_W-1:2]});
    sqa   = $signed({2'b00, qa});
    sqb   = $signed({2'b00, qb});
    dax = '0;
    day = '0;
    dbx = '0;
    dby = '0;
    res_d.overlap = sd.ov;
    res_d.hit_a   = 1'b0;
    res_d.hit_b   = 1'b0;
    if (sd.ov) begin
      if (sd.a_fixed) begin
        res_d.hit_b = 1'b1;
        if (sd.vert) dby = -half;
        else         dbx = -half;
      end else if (sd.b_fixed) begin
        res_d.hit_a = 1'b1;
        if (sd.vert) day = -half;
        else         dax = -half;
      end else if (sd.vert) begin
        day = sqa;
        dby = -sqb;
      end else begin
        dax = quart;
        dbx = -quart;
      end
    end
    res_d.new_a_x = aor_sat(SUM_W'(sd.a_x) + dax);
    res_d.new_a_y = aor_sat(SUM_W'(sd.a_y) + day);
    res_d.new_b_x = aor_sat(SUM_W'(sd.b_x) + dbx);
    res_d.new_b_y = aor_sat(SUM_W'(sd.b_y) + dby);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vd;
    end
  end
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o   = 1'b0;
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire
